// File: hw/rtl/dtl_pkg.sv
// Shared widths, command and status codes, and sequencer states for the deadline task list.
`timescale 1ns / 1ps

package dtl_pkg;

    localparam int ACTION_W = 2;
    localparam int TAG_W    = 8;
    localparam int TIME_W   = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 3;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_FIRED   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ADDED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REMOVED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BADIDX  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_IDLE    = 3'd5;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

endpackage

// File: hw/rtl/deadline_task_list.sv
// Top level of the deadline task list: entry memory, time count and scan sequencer.
`timescale 1ns / 1ps
//
// A request is taken on a rising edge with start high and busy low; action, task_tag,
// delay and entry_index are sampled there. Results come out on status, fired_tag and
// last, each valid for exactly one cycle while strobe is high; the receiver cannot
// stall them and must take every strobe. last marks the final result of a request.
//
// Add, a rejected remove and an add to a full list answer in the cycle after the request
// and never raise busy. Unused action code 3 gives no result and no busy.
// Tick and a valid remove walk the whole list through the entry memory:
// one entry read per cycle, with each kept entry written back at the lowest free place.
// busy stays high until the walk has ended, also on a tick of an empty list. On a tick
// each fired entry is reported in the cycle after the next one is found, and the final
// result (last fired entry, or the idle status) follows the end of the walk.
//
// Reset clears the entry count and the time count; the memory itself is not cleared,
// since only entries below the count are ever used.
//
module deadline_task_list #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [dtl_pkg::ACTION_W-1:0]   action,
    input  logic [dtl_pkg::TAG_W-1:0]      task_tag,
    input  logic [dtl_pkg::TIME_W-1:0]     delay,
    input  logic [dtl_pkg::INDEX_W-1:0]    entry_index,
    output logic                           strobe,
    output logic [dtl_pkg::STATUS_W-1:0]   status,
    output logic [dtl_pkg::TAG_W-1:0]      fired_tag,
    output logic                           last
);

    import dtl_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic                mode_tick_reg, mode_tick_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [TAG_W-1:0]    pend_tag_reg, pend_tag_next;
    logic                strobe_reg, strobe_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TAG_W-1:0]    fired_reg, fired_next;
    logic                last_reg, last_next;

    logic [TIME_W-1:0]   dl_mem [LIST_DEPTH];
    logic [TAG_W-1:0]    tag_mem [LIST_DEPTH];
    logic [TIME_W-1:0]   rd_dl_reg;
    logic [TAG_W-1:0]    rd_tag_reg;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_wa;
    logic [TIME_W-1:0]   mem_wd_dl;
    logic [TAG_W-1:0]    mem_wd_tag;
    logic [IDX_W-1:0]    mem_ra;

    logic accept;
    logic full;
    logic bad_index;
    logic scan_more;
    logic scan_done;
    logic expired;
    logic drop;

    assign accept    = start && (state_reg == S_IDLE);
    assign full      = (count_reg >= CNT_W'(LIST_DEPTH));
    assign bad_index = (CMP_W'(entry_index) >= CMP_W'(count_reg));
    assign scan_more = (rd_ptr_reg < count_reg);
    assign scan_done = !scan_more && !rd_vld_reg;
    assign expired   = (time_reg >= rd_dl_reg);
    assign drop      = mode_tick_reg ? expired : (CMP_W'(idx_reg) == CMP_W'(rd_idx_reg));
    assign mem_ra    = rd_ptr_reg[IDX_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && ((action == ACT_TICK) ||
                               ((action == ACT_REMOVE) && !bad_index)))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory port and result outputs
    always_comb
    begin
        count_next     = count_reg;
        time_next      = time_reg;
        mode_tick_next = mode_tick_reg;
        idx_next       = idx_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_idx_next    = rd_idx_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_vld_next    = 1'b0;
        pend_vld_next  = pend_vld_reg;
        pend_tag_next  = pend_tag_reg;
        strobe_next    = 1'b0;
        status_next    = status_reg;
        fired_next     = fired_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_wa         = wr_ptr_reg[IDX_W-1:0];
        mem_wd_dl      = rd_dl_reg;
        mem_wd_tag     = rd_tag_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_tick_next = (action == ACT_TICK);
                    idx_next       = entry_index;
                    rd_ptr_next    = '0;
                    wr_ptr_next    = '0;
                    pend_vld_next  = 1'b0;
                    case (action)
                        ACT_ADD:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            fired_next  = '0;
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next = STAT_ADDED;
                                mem_we      = 1'b1;
                                mem_wa      = count_reg[IDX_W-1:0];
                                mem_wd_dl   = time_reg + delay;
                                mem_wd_tag  = task_tag;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_TICK:
                        begin
                            time_next = time_reg + TIME_W'(1);
                        end
                        ACT_REMOVE:
                        begin
                            if (bad_index)
                            begin
                                strobe_next = 1'b1;
                                last_next   = 1'b1;
                                fired_next  = '0;
                                status_next = STAT_BADIDX;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_more)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_ptr_reg;
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (drop)
                    begin
                        // hold the newest fired entry until it is known whether it is the last
                        if (mode_tick_reg)
                        begin
                            if (pend_vld_reg)
                            begin
                                strobe_next = 1'b1;
                                status_next = STAT_FIRED;
                                fired_next  = pend_tag_reg;
                                last_next   = 1'b0;
                            end
                            pend_vld_next = 1'b1;
                            pend_tag_next = rd_tag_reg;
                        end
                    end
                    else
                    begin
                        // compact: move the kept entry down to the write pointer
                        mem_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                end
                if (scan_done)
                begin
                    count_next  = wr_ptr_reg;
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    if (mode_tick_reg)
                    begin
                        if (pend_vld_reg)
                        begin
                            status_next = STAT_FIRED;
                            fired_next  = pend_tag_reg;
                        end
                        else
                        begin
                            status_next = STAT_IDLE;
                            fired_next  = '0;
                        end
                    end
                    else
                    begin
                        status_next = STAT_REMOVED;
                        fired_next  = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            time_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            time_reg     <= time_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_tick_reg <= mode_tick_next;
        idx_reg       <= idx_next;
        rd_ptr_reg    <= rd_ptr_next;
        rd_idx_reg    <= rd_idx_next;
        wr_ptr_reg    <= wr_ptr_next;
        pend_tag_reg  <= pend_tag_next;
        status_reg    <= status_next;
        fired_reg     <= fired_next;
        last_reg      <= last_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dl_mem[mem_wa]  <= mem_wd_dl;
            tag_mem[mem_wa] <= mem_wd_tag;
        end
        rd_dl_reg  <= dl_mem[mem_ra];
        rd_tag_reg <= tag_mem[mem_ra];
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign status    = status_reg;
    assign fired_tag = fired_reg;
    assign last      = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count above list depth");

    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (wr_ptr_reg <= rd_ptr_reg))
        else $error("compaction write pointer passed read pointer");

    a_add_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_ADD)) |=> (strobe && last && !busy))
        else $error("add request gave no single final result");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && scan_done) |=> (strobe && last && !busy))
        else $error("scan end gave no final result");

    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status != STAT_FIRED)) |-> ((fired_tag == '0) && last))
        else $error("non-fired result with tag or without last");

endmodule

// File: tb/sv/tb_deadline_task_list.sv
// Testbench for the deadline task list: directed and random requests checked against a shadow list.
`timescale 1ns / 1ps

module tb_deadline_task_list;
    import dtl_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   delay;
        logic [INDEX_W-1:0]  index;
    } task_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic                last;
    } list_result_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ACTION_W-1:0] action = '0;
    logic [TAG_W-1:0]    task_tag = '0;
    logic [TIME_W-1:0]   delay = '0;
    logic [INDEX_W-1:0]  entry_index = '0;
    logic                strobe;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    fired_tag;
    logic                last;

    task_request_t pending_requests[$];
    task_request_t cur_req;
    list_result_t  owed_results[$];

    // shadow copy of the task list
    logic [TIME_W-1:0] shadow_due [LIST_DEPTH];
    logic [TAG_W-1:0]  shadow_tag [LIST_DEPTH];
    int                shadow_count = 0;
    logic [TIME_W-1:0] shadow_now = '0;

    int mismatches = 0;
    int quiet_cycles = 0;
    int idle_left = 0;
    int calm_left = 0;
    int gap_now;

    deadline_task_list #(
        .LIST_DEPTH(LIST_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .task_tag(task_tag),
        .delay(delay),
        .entry_index(entry_index),
        .strobe(strobe),
        .status(status),
        .fired_tag(fired_tag),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic owe(input logic [STATUS_W-1:0] st, input logic [TAG_W-1:0] tg,
                       input logic lst);
        list_result_t res;
        res.status = st;
        res.tag    = tg;
        res.last   = lst;
        owed_results.push_back(res);
    endtask

    // close the gap left by the entry at pos
    task automatic shadow_drop(input int pos);
        for (int i = pos + 1; i < shadow_count; i++)
        begin
            shadow_due[i-1] = shadow_due[i];
            shadow_tag[i-1] = shadow_tag[i];
        end
        shadow_count--;
    endtask

    task automatic shadow_apply(input task_request_t req);
        logic [TAG_W-1:0] hit_tags [LIST_DEPTH];
        int hits;
        int i;
        hits = 0;
        i = 0;
        case (req.action)
            ACT_ADD:
                if (shadow_count >= LIST_DEPTH)
                    owe(STAT_FULL, '0, 1'b1);
                else
                begin
                    shadow_due[shadow_count] = shadow_now + req.delay;
                    shadow_tag[shadow_count] = req.tag;
                    shadow_count++;
                    owe(STAT_ADDED, '0, 1'b1);
                end
            ACT_REMOVE:
                if (int'(req.index) >= shadow_count)
                    owe(STAT_BADIDX, '0, 1'b1);
                else
                begin
                    shadow_drop(int'(req.index));
                    owe(STAT_REMOVED, '0, 1'b1);
                end
            ACT_TICK:
            begin
                shadow_now = shadow_now + 1;
                while (i < shadow_count)
                begin
                    if (shadow_now >= shadow_due[i])
                    begin
                        hit_tags[hits] = shadow_tag[i];
                        hits++;
                        shadow_drop(i);
                    end
                    else
                        i++;
                end
                if (hits == 0)
                    owe(STAT_IDLE, '0, 1'b1);
                for (int k = 0; k < hits; k++)
                    owe(STAT_FIRED, hit_tags[k], k == hits - 1);
            end
            default:
                ;
        endcase
    endtask

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic queue_request(input logic [ACTION_W-1:0] act, input logic [TAG_W-1:0] tg,
                                 input logic [TIME_W-1:0] dly, input logic [INDEX_W-1:0] idx);
        task_request_t req;
        req.action = act;
        req.tag    = tg;
        req.delay  = dly;
        req.index  = idx;
        pending_requests.push_back(req);
    endtask

    // mostly short delays so tasks fire soon; some huge or wrapping
    function automatic logic [TIME_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 8);
        else if (r < 75)
            return $urandom_range(9, 60);
        else if (r < 88)
            return $urandom;
        else
            return 32'hFFFF_FFFF - $urandom_range(0, 20);
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        else if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // driver: present the next request once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            idle_left <= 0;
        end
        else if (!start || !busy)
        begin
            if (start)
            begin
                shadow_apply(cur_req);
                gap_now = pick_gap();
            end
            else
                gap_now = idle_left;
            if (gap_now > 0)
            begin
                start     <= 1'b0;
                idle_left <= gap_now - 1;
            end
            else if (pending_requests.size() > 0)
            begin
                cur_req = pending_requests.pop_front();
                action      <= cur_req.action;
                task_tag    <= cur_req.tag;
                delay       <= cur_req.delay;
                entry_index <= cur_req.index;
                start       <= 1'b1;
                idle_left   <= 0;
            end
            else
            begin
                start     <= 1'b0;
                idle_left <= 0;
            end
        end
    end

    // monitor: every strobe must match the oldest owed result
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && strobe)
        begin
            if (owed_results.size() == 0)
                flag_error($sformatf("unexpected result status=%0d tag=%0h last=%0b",
                                     status, fired_tag, last));
            else
            begin
                want = owed_results.pop_front();
                if (status !== want.status || fired_tag !== want.tag || last !== want.last)
                    flag_error($sformatf("exp status=%0d tag=%0h last=%0b, got %0d %0h %0b",
                                         want.status, want.tag, want.last,
                                         status, fired_tag, last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        int phase;
        int add_cut;
        int tick_cut;

        // empty list, wrapped deadline, burst, full list, both remove outcomes
        queue_request(ACT_TICK, 8'h00, 32'h0, 4'd0);
        queue_request(ACT_REMOVE, 8'h00, 32'h0, 4'd0);
        queue_request(ACT_ADD, 8'hFF, 32'h0, 4'd0);
        queue_request(ACT_ADD, 8'h00, 32'hFFFF_FFFF, 4'd0);
        queue_request(ACT_ADD, 8'hA5, 32'd3, 4'd0);
        queue_request(ACT_TICK, 8'h00, 32'h0, 4'd0);
        queue_request(ACT_REMOVE, 8'h00, 32'h0, 4'd15);
        queue_request(ACT_UNUSED, 8'h5A, 32'hAAAA_5555, 4'd10);
        for (int k = 0; k < 15; k++)
            queue_request(ACT_ADD, TAG_W'(8'h10 + k),
                          (k == 14) ? 32'h7FFF_FFFF : TIME_W'(k % 3), INDEX_W'(k));
        queue_request(ACT_ADD, 8'hC3, 32'h0, 4'd0);
        queue_request(ACT_REMOVE, 8'h00, 32'h0, 4'd15);
        queue_request(ACT_TICK, 8'h00, 32'h0, 4'd0);

        // alternate fill, mixed and drain stretches
        for (int n = 0; n < 345; n++)
        begin
            phase = (n / 30) % 3;
            add_cut  = (phase == 0) ? 60 : (phase == 1) ? 38 : 15;
            tick_cut = (phase == 0) ? 80 : (phase == 1) ? 75 : 80;
            r = $urandom_range(0, 99);
            if (r < add_cut)
                queue_request(ACT_ADD, TAG_W'($urandom_range(0, 255)), pick_delay(),
                              INDEX_W'($urandom_range(0, 15)));
            else if (r < tick_cut)
                queue_request(ACT_TICK, TAG_W'($urandom_range(0, 255)), $urandom,
                              INDEX_W'($urandom_range(0, 15)));
            else if (r < 97)
                queue_request(ACT_REMOVE, TAG_W'($urandom_range(0, 255)), $urandom,
                              INDEX_W'($urandom_range(0, 15)));
            else
                queue_request(ACT_UNUSED, TAG_W'($urandom_range(0, 255)), $urandom,
                              INDEX_W'($urandom_range(0, 15)));
        end

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() > 0 || start || owed_results.size() > 0)
            @(posedge clk);
        repeat (LIST_DEPTH + 6) @(posedge clk);

        if (mismatches == 0 && owed_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: deadline_task_list.f
hw/rtl/dtl_pkg.sv
hw/rtl/deadline_task_list.sv
tb/sv/tb_deadline_task_list.sv
